// File: hdl/mmt_pkg.sv
// Shared types, constants and helpers for the message mailbox table.
package mmt_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int BODY_BITS = 32;

  localparam int FIELD_BODY_W = 32;
  localparam int PID_W        = 8;
  localparam int PEND_W       = 5;

  localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_RAW_W = $clog2(NUM_SLOTS + 1);
  localparam int CNT_W  = (CNT_RAW_W > PEND_W) ? CNT_RAW_W : PEND_W;
  localparam int WIDE_W = (BODY_BITS > FIELD_BODY_W) ? BODY_BITS : FIELD_BODY_W;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  localparam logic FUNC_SEND = 1'b0;
  localparam logic FUNC_RECV = 1'b1;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  typedef logic [BODY_BITS-1:0] body_t;
  typedef logic [CNT_W-1:0]     count_t;

  typedef struct packed {
    logic [PID_W-1:0] src;
    logic [PID_W-1:0] dst;
    body_t            body;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
    logic ok;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
    logic last;
    logic empty;
    logic is_recv;
    logic out_free;
  } sts_t;

  function automatic body_t fit_body(input logic [FIELD_BODY_W-1:0] w);
    logic [WIDE_W-1:0] tmp;
    tmp = WIDE_W'(w);
    return tmp[BODY_BITS-1:0];
  endfunction

  function automatic logic [FIELD_BODY_W-1:0] field_body(input body_t b);
    logic [WIDE_W-1:0] tmp;
    tmp = WIDE_W'(b);
    return tmp[FIELD_BODY_W-1:0];
  endfunction

endpackage

// File: hdl/mmt_datapath.sv
// Slot store, scan pointer, match logic, message count and result register.
module mmt_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  mmt_pkg::cmd_t               cmd,
  output mmt_pkg::sts_t               sts,
  input  logic                        func,
  input  logic [7:0]                  caller_pid,
  input  logic [7:0]                  peer_pid,
  input  logic                        any_source,
  input  logic [31:0]                 body_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        status,
  output logic [4:0]                  pending_count,
  output logic [31:0]                 body_out,
  output logic [7:0]                  source_out
);
  import mmt_pkg::*;

  logic               req_func;
  logic [PID_W-1:0]   req_caller;
  logic [PID_W-1:0]   req_peer;
  logic               req_any;
  body_t              req_body;

  logic [NUM_SLOTS-1:0] slot_valid;
  count_t               count;
  entry_t               slot_mem [NUM_SLOTS];

  logic [IDX_W-1:0] ptr;
  logic             issue_end;
  logic             stage_live;
  logic [IDX_W-1:0] stage_idx;
  logic             stage_vld;
  entry_t           stage_entry;

  logic   match;
  logic   mem_wr;
  count_t count_inc;
  count_t count_dec;

  assign count_inc = count + count_t'(1);
  assign count_dec = count - count_t'(1);

  always_comb begin
    if (req_func == FUNC_SEND) begin
      match = !stage_vld;
    end else begin
      match = stage_vld && (stage_entry.dst == req_caller) &&
              (req_any || (stage_entry.src == req_peer));
    end
  end

  assign sts.hit      = stage_live && match;
  assign sts.last     = stage_live && (stage_idx == LAST_IDX);
  assign sts.empty    = (count == '0);
  assign sts.is_recv  = (req_func == FUNC_RECV);
  assign sts.out_free = !out_valid || out_ready;

  assign mem_wr = cmd.finish && cmd.ok && (req_func == FUNC_SEND);

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      count      <= '0;
      issue_end  <= 1'b0;
      stage_live <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        issue_end  <= 1'b0;
        stage_live <= 1'b0;
      end else if (cmd.step) begin
        stage_live <= !issue_end;
        if (ptr == LAST_IDX) begin
          issue_end <= 1'b1;
        end
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
        if (cmd.ok) begin
          if (req_func == FUNC_SEND) begin
            slot_valid[stage_idx] <= 1'b1;
            count <= count_inc;
          end else begin
            slot_valid[stage_idx] <= 1'b0;
            count <= count_dec;
          end
        end
      end
    end
  end

  // Request, scan and result words.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_func   <= func;
      req_caller <= caller_pid;
      req_peer   <= peer_pid;
      req_any    <= any_source;
      req_body   <= fit_body(body_in);
      ptr        <= '0;
    end else if (cmd.step) begin
      stage_idx <= ptr;
      stage_vld <= slot_valid[ptr];
      if (ptr != LAST_IDX) begin
        ptr <= ptr + IDX_W'(1);
      end
    end
    if (cmd.finish) begin
      if (!cmd.ok) begin
        status        <= ST_FAIL;
        pending_count <= '0;
        body_out      <= '0;
        source_out    <= '0;
      end else if (req_func == FUNC_SEND) begin
        status        <= ST_OK;
        pending_count <= count_inc[PEND_W-1:0];
        body_out      <= '0;
        source_out    <= '0;
      end else begin
        status        <= ST_OK;
        pending_count <= count_dec[PEND_W-1:0];
        body_out      <= field_body(stage_entry.body);
        source_out    <= stage_entry.src;
      end
    end
  end

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_wr) begin
      slot_mem[stage_idx] <= '{src: req_caller, dst: req_peer, body: req_body};
    end
    if (cmd.step) begin
      stage_entry <= slot_mem[ptr];
    end
  end

  a_count_tracks_valid: assert property (@(posedge clk) disable iff (rst)
    count == count_t'($countones(slot_valid)))
    else $error("message count differs from number of valid slots");

  a_finish_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("result written over a word not yet taken");

  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("finished request produced no result word");

  a_hit_only_live: assert property (@(posedge clk) disable iff (rst)
    sts.hit |-> !cmd.step)
    else $error("scan advanced past a matching slot");

endmodule

// File: hdl/mmt_ctrl.sv
// Request sequencer: accepts a word, steps the slot scan and hands off the result.
module mmt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  mmt_pkg::sts_t sts,
  output mmt_pkg::cmd_t cmd
);
  import mmt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       ok;
  logic       ok_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ok_next    = ok;
    cmd        = '0;
    cmd.ok     = ok;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        // A receive with no message held fails without scanning.
        priority if (sts.is_recv && sts.empty) begin
          ok_next    = 1'b0;
          state_next = S_DONE;
        end else if (sts.hit) begin
          ok_next    = 1'b1;
          state_next = S_DONE;
        end else if (sts.last) begin
          ok_next    = 1'b0;
          state_next = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ok    <= 1'b0;
    end else begin
      state <= state_next;
      ok    <= ok_next;
    end
  end

endmodule

// File: hdl/message_mailbox_table_core.sv
// Top level of the message mailbox table: sequencer plus slot datapath.
//
//   Channel  Handshake            Word
//   in       in_valid / in_ready  func, caller_pid, peer_pid, any_source, body_in
//   out      out_valid/ out_ready status, pending_count, body_out, source_out
//
// A request is loaded, then the scan reads one slot per cycle through the slot
// memory read port up to the match or the last slot, and the result is written
// once the output register is free. A receive with no message held fails without scanning.
// Synchronous reset empties every slot and zeroes the count at once.
// A new word is taken while a result still waits; its result is held back
// until the output register has been emptied.
module message_mailbox_table_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [7:0]  caller_pid,
  input  logic [7:0]  peer_pid,
  input  logic        any_source,
  input  logic [31:0] body_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        status,
  output logic [4:0]  pending_count,
  output logic [31:0] body_out,
  output logic [7:0]  source_out
);
  import mmt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mmt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mmt_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .func          (func),
    .caller_pid    (caller_pid),
    .peer_pid      (peer_pid),
    .any_source    (any_source),
    .body_in       (body_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .pending_count (pending_count),
    .body_out      (body_out),
    .source_out    (source_out)
  );

endmodule

// File: verif/tb_message_mailbox_table_core.sv
// Self-checking testbench for the message mailbox table core.
module tb_message_mailbox_table_core;
  import mmt_pkg::*;

  typedef struct packed {
    logic              status;
    logic [PEND_W-1:0] count;
    logic [31:0]       body;
    logic [PID_W-1:0]  source;
  } reply_t;

  localparam int RUN_LIMIT   = 400000;
  localparam int TAIL_CYCLES = 40;
  localparam int HOLD_CYCLES = 150;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        func = FUNC_SEND;
  logic [7:0]  caller_pid = '0;
  logic [7:0]  peer_pid = '0;
  logic        any_source = 1'b0;
  logic [31:0] body_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        status;
  logic [4:0]  pending_count;
  logic [31:0] body_out;
  logic [7:0]  source_out;

  // Our own copy of the mailbox contents.
  logic             box_valid [NUM_SLOTS];
  logic [PID_W-1:0] box_src   [NUM_SLOTS];
  logic [PID_W-1:0] box_dst   [NUM_SLOTS];
  body_t            box_body  [NUM_SLOTS];
  int               box_count;

  reply_t expected_replies[$];
  int     in_idle_pct = 19;
  int     out_idle_pct = 50;
  int     hold_req = 0;
  int     mismatches = 0;
  int     cycle_count = 0;

  message_mailbox_table_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .caller_pid(caller_pid), .peer_pid(peer_pid),
    .any_source(any_source), .body_in(body_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .pending_count(pending_count),
    .body_out(body_out), .source_out(source_out)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Applies one word to the mailbox copy and returns the reply it should give.
  function automatic reply_t mailbox_apply(logic f, logic [7:0] caller, logic [7:0] peer,
                                           logic any, logic [31:0] b);
    reply_t r;
    r = '0;
    r.status = ST_FAIL;
    if (f == FUNC_SEND) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!box_valid[i]) begin
          box_valid[i] = 1'b1;
          box_src[i] = caller;
          box_dst[i] = peer;
          box_body[i] = body_t'(b);
          box_count++;
          r.status = ST_OK;
          r.count = PEND_W'(box_count);
          return r;
        end
      end
    end else if (box_count > 0) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (box_valid[i] && box_dst[i] == caller && (any || box_src[i] == peer)) begin
          box_valid[i] = 1'b0;
          box_count--;
          r.status = ST_OK;
          r.count = PEND_W'(box_count);
          r.body = 32'(box_body[i]);
          r.source = box_src[i];
          return r;
        end
      end
    end
    return r;
  endfunction

  // Offers one word, possibly after a random gap, and records its reply once taken.
  task automatic send_word(input logic f, input logic [7:0] caller, input logic [7:0] peer,
                           input logic any, input logic [31:0] b);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid   <= 1'b1;
    func       <= f;
    caller_pid <= caller;
    peer_pid   <= peer;
    any_source <= any;
    body_in    <= b;
    do @(posedge clk); while (!in_ready);
    expected_replies.push_back(mailbox_apply(f, caller, peer, any, b));
  endtask

  // Mostly a handful of ids so that receives find their messages.
  function automatic logic [7:0] pick_pid();
    return ($urandom_range(99) < 75) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
  endfunction

  task automatic send_random_word(input int send_pct);
    int          held[$];
    int          idx;
    logic [7:0]  caller;
    logic [7:0]  peer;
    logic        any;
    if ($urandom_range(99) < send_pct) begin
      send_word(FUNC_SEND, pick_pid(), pick_pid(), 1'($urandom_range(1)), $urandom);
    end else begin
      for (int i = 0; i < NUM_SLOTS; i++)
        if (box_valid[i]) held.push_back(i);
      any = 1'($urandom_range(1));
      if (held.size() > 0 && $urandom_range(99) < 80) begin
        // Aim at a message that is really held.
        idx = held[$urandom_range(held.size() - 1)];
        caller = box_dst[idx];
        peer = any ? pick_pid() : box_src[idx];
      end else begin
        caller = pick_pid();
        peer = pick_pid();
      end
      send_word(FUNC_RECV, caller, peer, any, $urandom);
    end
  endtask

  task automatic test_extremes();
    send_word(FUNC_RECV, 8'h00, 8'h00, 1'b1, 32'hFFFF_FFFF);
    send_word(FUNC_SEND, 8'h00, 8'hFF, 1'b1, 32'h0000_0000);
    send_word(FUNC_SEND, 8'hFF, 8'h00, 1'b0, 32'hFFFF_FFFF);
    send_word(FUNC_RECV, 8'h00, 8'h00, 1'b0, 32'h0);
    send_word(FUNC_RECV, 8'hFF, 8'h12, 1'b1, 32'h0);
    send_word(FUNC_RECV, 8'h00, 8'hFF, 1'b0, 32'h0);
  endtask

  task automatic test_full_table();
    for (int i = 0; i <= NUM_SLOTS; i++)
      send_word(FUNC_SEND, 8'(i), 8'(i % 4), 1'($urandom_range(1)), $urandom);
  endtask

  task automatic test_random(input int count);
    for (int k = 0; k < count; k++)
      send_random_word(((k / 24) % 2 == 0) ? 30 : 75);
  endtask

  // The receiver stops for a long stretch while words keep coming.
  task automatic test_backpressure();
    int saved_pct;
    saved_pct = in_idle_pct;
    in_idle_pct = 0;
    hold_req = HOLD_CYCLES;
    for (int k = 0; k < 24; k++) send_random_word(60);
    in_idle_pct = saved_pct;
  endtask

  task automatic check_reply();
    reply_t got;
    reply_t want;
    got = '{status, pending_count, body_out, source_out};
    if (expected_replies.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected result word: %p", got);
    end else begin
      want = expected_replies.pop_front();
      if (got.status !== want.status || got.count !== want.count ||
          got.body !== want.body || got.source !== want.source) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Result mismatch: expected %p, got %p", want, got);
      end
    end
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) check_reply();
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) box_valid[i] = 1'b0;
    box_count = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extremes();
    test_full_table();
    test_random(160);

    in_idle_pct = 50;
    out_idle_pct = 19;
    test_backpressure();
    test_random(150);

    in_idle_pct = 0;
    out_idle_pct = 0;
    test_random(150);

    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
